// ----- hw/rtl/rv32_alu_pkg.sv -----
// Package: operation codes, pipeline depth and shared types for the RV32IM ALU
`timescale 1ns / 1ps
`default_nettype none
package rv32_alu_pkg;

  localparam int XLEN = 32;
  localparam int DIV_STAGES = 32;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_SLL    = 5'd2,
    OP_SRL    = 5'd3,
    OP_SRA    = 5'd4,
    OP_SLT    = 5'd5,
    OP_SLTU   = 5'd6,
    OP_XOR    = 5'd7,
    OP_OR     = 5'd8,
    OP_AND    = 5'd9,
    OP_MUL    = 5'd10,
    OP_MULH   = 5'd11,
    OP_MULHSU = 5'd12,
    OP_MULHU  = 5'd13,
    OP_DIV    = 5'd14,
    OP_DIVU   = 5'd15,
    OP_REM    = 5'd16,
    OP_REMU   = 5'd17,
    OP_PASSB  = 5'd18,
    OP_NONE   = 5'd19
  } op_t;

  // Divider stage contents: partial remainder, quotient bits, divisor magnitude
  typedef struct packed {
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] quo;
    logic [XLEN-1:0] dsr;
  } div_state_t;

  // Sideband carried along the divider
  typedef struct packed {
    logic            want_rem;
    logic            neg_q;
    logic            neg_r;
    logic            by_zero;
    logic            ovf;
    logic [XLEN-1:0] dividend;
  } div_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rv32im_integer_alu_top.sv -----
// Top level of the pipelined RV32IM integer ALU
//
//  channel | handshake     | payload
//  in      | valid, stall  | kind, operand_a, operand_b
//  out     | out_valid, out_stall | result
//
// Every operation takes the same path length to the output register; one beat
// enters per cycle unless the input stalls. All operations share one pipeline, its
// length set by the one-bit-per-stage divider. Reset clears only the valid
// bits. A stall on the output freezes the whole pipeline while a result waits,
// and the input stalls for exactly as long as that result waits.
`timescale 1ns / 1ps
`default_nettype none
module rv32im_integer_alu_top
  import rv32_alu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic [4:0]  kind,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] result
);

  localparam int DEPTH = DIV_STAGES + 1;

  localparam logic [1:0] SEL_SIMPLE = 2'd0;
  localparam logic [1:0] SEL_MUL    = 2'd1;
  localparam logic [1:0] SEL_DIV    = 2'd2;

  logic            adv;
  logic            in_beat;
  logic [XLEN-1:0] simple;
  logic [XLEN-1:0] mul_res;
  logic [XLEN-1:0] div_res;
  logic [DEPTH-1:0] vld;
  logic [XLEN-1:0] simple_pipe [DEPTH-1];
  logic [1:0]      sel_pipe    [DEPTH-1];
  logic [1:0]      sel_in;
  logic [XLEN-1:0] mul_delay   [DEPTH-3];
  logic [XLEN-1:0] out_next;

  // Advance when the output slot is free or being taken
  assign adv     = !out_valid || !out_stall;
  assign stall   = !adv;
  assign in_beat = valid && adv;

  // Operations computed combinationally at the input
  always_comb begin
    case (op_t'(kind))
      OP_ADD:   simple = operand_a + operand_b;
      OP_SUB:   simple = operand_a - operand_b;
      OP_SLL:   simple = operand_a << operand_b[4:0];
      OP_SRL:   simple = operand_a >> operand_b[4:0];
      OP_SRA:   simple = XLEN'($signed(operand_a) >>> operand_b[4:0]);
      OP_SLT:   simple = {31'd0, $signed(operand_a) < $signed(operand_b)};
      OP_SLTU:  simple = {31'd0, operand_a < operand_b};
      OP_XOR:   simple = operand_a ^ operand_b;
      OP_OR:    simple = operand_a | operand_b;
      OP_AND:   simple = operand_a & operand_b;
      OP_PASSB: simple = operand_b;
      default:  simple = '0;
    endcase
  end

  // Pick the unit whose answer is kept
  always_comb begin
    case (op_t'(kind))
      OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU: sel_in = SEL_MUL;
      OP_DIV, OP_DIVU, OP_REM, OP_REMU:     sel_in = SEL_DIV;
      default:                              sel_in = SEL_SIMPLE;
    endcase
  end

  rv32_alu_mul u_mul (
    .clk       (clk),
    .en        (adv),
    .a         (operand_a),
    .b         (operand_b),
    .a_signed  (kind == OP_MULH || kind == OP_MULHSU),
    .b_signed  (kind == OP_MULH),
    .want_high (kind != OP_MUL),
    .prod      (mul_res)
  );

  rv32_alu_div u_div (
    .clk       (clk),
    .en        (adv),
    .a         (operand_a),
    .b         (operand_b),
    .is_signed (kind == OP_DIV || kind == OP_REM),
    .want_rem  (kind == OP_REM || kind == OP_REMU),
    .res       (div_res)
  );

  // Carry valid bits, selects and simple results alongside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_beat};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      simple_pipe[0] <= simple;
      sel_pipe[0]    <= sel_in;
      for (int i = 1; i < DEPTH-1; i++) begin
        simple_pipe[i] <= simple_pipe[i-1];
        sel_pipe[i]    <= sel_pipe[i-1];
      end
      mul_delay[0] <= mul_res;
      for (int i = 1; i < DEPTH-3; i++) begin
        mul_delay[i] <= mul_delay[i-1];
      end
    end
  end

  // Merge into the output register
  always_comb begin
    case (sel_pipe[DEPTH-2])
      SEL_MUL: out_next = mul_delay[DEPTH-4];
      SEL_DIV: out_next = div_res;
      default: out_next = simple_pipe[DEPTH-2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DEPTH-2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= out_next;
    end
  end

  // A stalled result holds its valid and value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("stalled result changed");

  // Stall comes only from a waiting output
  a_stall: assert property (@(posedge clk) disable iff (rst)
    stall |-> out_valid && out_stall)
    else $error("stall without waiting output");

  // A frozen pipeline keeps its valid bits
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ----- hw/rtl/rv32_alu_mul.sv -----
// Pipelined 33x33 signed multiplier built from four 17x17 partial products
`timescale 1ns / 1ps
`default_nettype none
module rv32_alu_mul
  import rv32_alu_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [XLEN-1:0] a,
  input  wire logic [XLEN-1:0] b,
  input  wire logic            a_signed,
  input  wire logic            b_signed,
  input  wire logic            want_high,
  output logic      [XLEN-1:0] prod
);

  logic signed [32:0] ax;
  logic signed [32:0] bx;
  logic signed [16:0] ahi;
  logic signed [16:0] bhi;
  logic        [15:0] alo;
  logic        [15:0] blo;
  logic signed [33:0] p_hh;
  logic signed [33:0] p_hl;
  logic signed [33:0] p_lh;
  logic        [31:0] p_ll;
  logic               hi1;
  logic signed [65:0] full;
  logic               hi2;

  assign ax  = {a_signed & a[XLEN-1], a};
  assign bx  = {b_signed & b[XLEN-1], b};
  assign ahi = ax[32:16];
  assign bhi = bx[32:16];
  assign alo = ax[15:0];
  assign blo = bx[15:0];

  // Register the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p_hh <= ahi * bhi;
      p_hl <= ahi * $signed({1'b0, blo});
      p_lh <= $signed({1'b0, alo}) * bhi;
      p_ll <= alo * blo;
      hi1  <= want_high;
    end
  end

  // Sum the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      full <= (66'(p_hh) <<< 32) + (66'(p_hl) <<< 16) + (66'(p_lh) <<< 16)
              + $signed({34'd0, p_ll});
      hi2  <= hi1;
    end
  end

  assign prod = hi2 ? full[63:32] : full[31:0];

endmodule
`default_nettype wire

// ----- hw/rtl/rv32_alu_div.sv -----
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rv32_alu_div
  import rv32_alu_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [XLEN-1:0] a,
  input  wire logic [XLEN-1:0] b,
  input  wire logic            is_signed,
  input  wire logic            want_rem,
  output logic      [XLEN-1:0] res
);

  div_state_t      st0;
  div_ctl_t        ctl0;
  div_state_t      st  [1:DIV_STAGES];
  div_ctl_t        ctl [1:DIV_STAGES];
  logic [XLEN-1:0] q_fix;
  logic [XLEN-1:0] r_fix;

  // Form magnitudes and special-case flags at the entry
  always_comb begin
    st0.rem       = '0;
    st0.quo       = (is_signed & a[XLEN-1]) ? -a : a;
    st0.dsr       = (is_signed & b[XLEN-1]) ? -b : b;
    ctl0.want_rem = want_rem;
    ctl0.neg_q    = is_signed & (a[XLEN-1] ^ b[XLEN-1]);
    ctl0.neg_r    = is_signed & a[XLEN-1];
    ctl0.by_zero  = (b == '0);
    ctl0.ovf      = is_signed & (a == {1'b1, {(XLEN-1){1'b0}}}) & (&b);
    ctl0.dividend = a;
  end

  // One shift-subtract step per stage
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
    div_state_t    cur;
    div_ctl_t      cur_ctl;
    logic [XLEN:0] trial;
    logic [XLEN:0] shifted;
    if (i == 0) begin : g_first
      assign cur     = st0;
      assign cur_ctl = ctl0;
    end else begin : g_rest
      assign cur     = st[i];
      assign cur_ctl = ctl[i];
    end
    assign shifted = {cur.rem, cur.quo[XLEN-1]};
    assign trial   = shifted - {1'b0, cur.dsr};
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1].dsr <= cur.dsr;
        if (!trial[XLEN]) begin
          st[i+1].rem <= trial[XLEN-1:0];
          st[i+1].quo <= {cur.quo[XLEN-2:0], 1'b1};
        end else begin
          st[i+1].rem <= shifted[XLEN-1:0];
          st[i+1].quo <= {cur.quo[XLEN-2:0], 1'b0};
        end
        ctl[i+1] <= cur_ctl;
      end
    end
  end

  // Apply signs and special cases
  always_comb begin
    div_ctl_t c;
    c     = ctl[DIV_STAGES];
    q_fix = c.neg_q ? -st[DIV_STAGES].quo : st[DIV_STAGES].quo;
    r_fix = c.neg_r ? -st[DIV_STAGES].rem : st[DIV_STAGES].rem;
    if (c.by_zero) begin
      q_fix = '1;
      r_fix = c.dividend;
    end else if (c.ovf) begin
      q_fix = {1'b1, {(XLEN-1){1'b0}}};
      r_fix = '0;
    end
    res = c.want_rem ? r_fix : q_fix;
  end

endmodule
`default_nettype wire
